@@ src/tlpq_pkg.sv @@
// ---------------------------------------------------------------------------
// tlpq_pkg
// Types, constants and helpers shared by the three-level aging priority queue.
// ---------------------------------------------------------------------------
`default_nettype none

package tlpq_pkg;

    localparam int LEVEL_DEPTH = 64;
    localparam int WAIT_BITS   = 16;
    localparam int ID_BITS     = 16;
    localparam int THR_BITS    = 16;
    localparam int TOTAL_BITS  = 32;
    localparam int PTR_W       = $clog2(LEVEL_DEPTH);
    localparam int CNT_W       = $clog2(LEVEL_DEPTH + 1);

    localparam logic [THR_BITS-1:0] THR_RESET = THR_BITS'(5);

    // operation codes of an input item
    localparam logic OP_ADMIT = 1'b0;
    localparam logic OP_SERVE = 1'b1;

    // level field codes
    localparam logic [1:0] LEVEL_NONE = 2'd0;
    localparam logic [1:0] LEVEL_HIGH = 2'd1;
    localparam logic [1:0] LEVEL_MID  = 2'd2;
    localparam logic [1:0] LEVEL_LOW  = 2'd3;

    // internal level index
    localparam logic [1:0] LVL_H = 2'd0;
    localparam logic [1:0] LVL_M = 2'd1;
    localparam logic [1:0] LVL_L = 2'd2;

    typedef struct packed {
        logic               op;
        logic [ID_BITS-1:0] entry_id;
        logic [1:0]         level;
    } t_in_item;

    typedef struct packed {
        logic                  served_valid;
        logic [ID_BITS-1:0]    served_id;
        logic [1:0]            served_level;
        logic [WAIT_BITS-1:0]  served_wait;
        logic                  all_empty;
        logic                  admit_dropped;
        logic [TOTAL_BITS-1:0] total_served;
        logic [TOTAL_BITS-1:0] total_wait;
    } t_out_item;

    typedef struct packed {
        logic [ID_BITS-1:0]   id;
        logic [WAIT_BITS-1:0] wait_cnt;
    } t_entry;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_ADMIT,
        CMD_LOAD,
        CMD_AGE_RD,
        CMD_AGE_WR,
        CMD_ESC_RD,
        CMD_ESC_WR,
        CMD_POP_RD,
        CMD_POP_WR,
        CMD_EMPTY
    } t_cmd_op;

    typedef struct packed {
        t_cmd_op    op;
        logic [1:0] lvl;
        logic       accept;
    } t_cmd;

    typedef struct packed {
        logic cnt_zero;
        logic all_empty;
        logic out_free;
        logic item_op;
    } t_status;

    function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] a,
                                                  input logic [CNT_W-1:0] b);
        logic [CNT_W:0] s;
        s = (CNT_W+1)'(a) + (CNT_W+1)'(b);
        if (s >= (CNT_W+1)'(LEVEL_DEPTH)) begin
            s = s - (CNT_W+1)'(LEVEL_DEPTH);
        end
        return s[PTR_W-1:0];
    endfunction

    function automatic logic [WAIT_BITS-1:0] sat_inc(input logic [WAIT_BITS-1:0] w);
        return (w == {WAIT_BITS{1'b1}}) ? w : w + WAIT_BITS'(1);
    endfunction

endpackage

`default_nettype wire

@@ src/tlpq_ctrl.sv @@
// ---------------------------------------------------------------------------
// tlpq_ctrl
// Sequencer: admits an item, or walks the levels for aging and escalation and then pops.
// ---------------------------------------------------------------------------
`default_nettype none

module tlpq_ctrl (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_in_valid,
    output logic            o_in_ready,
    input  tlpq_pkg::t_status i_status,
    output tlpq_pkg::t_cmd  o_cmd
);
    import tlpq_pkg::*;

    typedef enum logic [11:0] {
        S_IDLE   = 12'b0000_0000_0001,
        S_DECODE = 12'b0000_0000_0010,
        S_ADMIT  = 12'b0000_0000_0100,
        S_AGE_LD = 12'b0000_0000_1000,
        S_AGE_RD = 12'b0000_0001_0000,
        S_AGE_WR = 12'b0000_0010_0000,
        S_ESC_LD = 12'b0000_0100_0000,
        S_ESC_RD = 12'b0000_1000_0000,
        S_ESC_WR = 12'b0001_0000_0000,
        S_POP_RD = 12'b0010_0000_0000,
        S_POP_WR = 12'b0100_0000_0000,
        S_EMPTY  = 12'b1000_0000_0000
    } t_state;

    t_state     r_state, n_state;
    logic [1:0] r_lvl, n_lvl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_lvl   <= LVL_H;
        end else begin
            r_state <= n_state;
            r_lvl   <= n_lvl;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state      = r_state;
        n_lvl        = r_lvl;
        o_cmd.op     = CMD_NONE;
        o_cmd.lvl    = r_lvl;
        o_cmd.accept = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_status.item_op == OP_SERVE) begin
                    n_lvl   = LVL_H;
                    n_state = S_AGE_LD;
                end else begin
                    n_state = S_ADMIT;
                end
            end
            S_ADMIT: begin
                if (i_status.out_free) begin
                    o_cmd.op = CMD_ADMIT;
                    n_state  = S_IDLE;
                end
            end
            S_AGE_LD: begin
                o_cmd.op = CMD_LOAD;
                n_state  = S_AGE_RD;
            end
            S_AGE_RD: begin
                if (i_status.cnt_zero) begin
                    // high then middle; low ages during its escalation walk
                    if (r_lvl == LVL_H) begin
                        n_lvl   = LVL_M;
                        n_state = S_AGE_LD;
                    end else begin
                        n_lvl   = LVL_L;
                        n_state = S_ESC_LD;
                    end
                end else begin
                    o_cmd.op = CMD_AGE_RD;
                    n_state  = S_AGE_WR;
                end
            end
            S_AGE_WR: begin
                o_cmd.op = CMD_AGE_WR;
                n_state  = S_AGE_RD;
            end
            S_ESC_LD: begin
                o_cmd.op = CMD_LOAD;
                n_state  = S_ESC_RD;
            end
            S_ESC_RD: begin
                if (i_status.cnt_zero) begin
                    if (r_lvl == LVL_L) begin
                        n_lvl   = LVL_M;
                        n_state = S_ESC_LD;
                    end else begin
                        n_state = S_POP_RD;
                    end
                end else begin
                    o_cmd.op = CMD_ESC_RD;
                    n_state  = S_ESC_WR;
                end
            end
            S_ESC_WR: begin
                o_cmd.op = CMD_ESC_WR;
                n_state  = S_ESC_RD;
            end
            S_POP_RD: begin
                if (i_status.all_empty) begin
                    n_state = S_EMPTY;
                end else begin
                    o_cmd.op = CMD_POP_RD;
                    n_state  = S_POP_WR;
                end
            end
            S_POP_WR: begin
                if (i_status.out_free) begin
                    o_cmd.op = CMD_POP_WR;
                    n_state  = S_IDLE;
                end
            end
            S_EMPTY: begin
                if (i_status.out_free) begin
                    o_cmd.op = CMD_EMPTY;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ src/tlpq_dp.sv @@
// ---------------------------------------------------------------------------
// tlpq_dp
// Level memories, head pointers, fill counts, totals and the result register.
// ---------------------------------------------------------------------------
`default_nettype none

module tlpq_dp (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  tlpq_pkg::t_cmd      i_cmd,
    output tlpq_pkg::t_status   o_status,
    input  tlpq_pkg::t_in_item  i_in,
    input  wire                 i_cfg_valid,
    input  wire [tlpq_pkg::THR_BITS-1:0] i_cfg_data,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output tlpq_pkg::t_out_item o_out
);
    import tlpq_pkg::*;

    t_entry mem_h [LEVEL_DEPTH];
    t_entry mem_m [LEVEL_DEPTH];
    t_entry mem_l [LEVEL_DEPTH];

    t_entry r_rd_h, r_rd_m, r_rd_l;
    logic [1:0] r_rd_lvl;

    logic [PTR_W-1:0] r_head [3];
    logic [PTR_W-1:0] n_head [3];
    logic [CNT_W-1:0] r_fill [3];
    logic [CNT_W-1:0] n_fill [3];

    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic [CNT_W-1:0]      r_idx, n_idx;
    logic [PTR_W-1:0]      r_waddr, n_waddr;
    logic [1:0]            r_pop_lvl, n_pop_lvl;
    logic [THR_BITS-1:0]   r_thr;
    logic [TOTAL_BITS-1:0] r_served, n_served;
    logic [TOTAL_BITS-1:0] r_wsum, n_wsum;
    t_in_item              r_item;
    t_out_item             r_out, n_out;
    logic                  r_out_valid, n_out_valid;

    logic             re, we;
    logic [1:0]       rlvl, wlvl, to_lvl, pop_q;
    logic [PTR_W-1:0] raddr, waddr;
    t_entry           wdata, rd, e;
    logic             move;
    logic [TOTAL_BITS:0] wsum_ext;
    logic [1:0]       adm_idx;

    // memories: one write and one registered read each
    always_ff @(posedge i_clk) begin
        if (we && wlvl == LVL_H) mem_h[waddr] <= wdata;
        if (we && wlvl == LVL_M) mem_m[waddr] <= wdata;
        if (we && wlvl == LVL_L) mem_l[waddr] <= wdata;
        if (re && rlvl == LVL_H) r_rd_h <= mem_h[raddr];
        if (re && rlvl == LVL_M) r_rd_m <= mem_m[raddr];
        if (re && rlvl == LVL_L) r_rd_l <= mem_l[raddr];
        if (re) r_rd_lvl <= rlvl;
    end

    always_comb begin
        case (r_rd_lvl)
            LVL_H:   rd = r_rd_h;
            LVL_M:   rd = r_rd_m;
            default: rd = r_rd_l;
        endcase
    end

    always_comb begin
        if (r_fill[0] != '0)      pop_q = LVL_H;
        else if (r_fill[1] != '0) pop_q = LVL_M;
        else                      pop_q = LVL_L;
    end

    assign to_lvl  = i_cmd.lvl - 2'd1;
    assign adm_idx = r_item.level - 2'd1;

    always_comb begin
        re          = 1'b0;
        we          = 1'b0;
        rlvl        = i_cmd.lvl;
        wlvl        = i_cmd.lvl;
        raddr       = r_head[i_cmd.lvl];
        waddr       = r_waddr;
        wdata       = rd;
        e           = rd;
        move        = 1'b0;
        wsum_ext    = '0;
        n_head      = r_head;
        n_fill      = r_fill;
        n_cnt       = r_cnt;
        n_idx       = r_idx;
        n_waddr     = r_waddr;
        n_pop_lvl   = r_pop_lvl;
        n_served    = r_served;
        n_wsum      = r_wsum;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        case (i_cmd.op)
            CMD_LOAD: begin
                n_cnt = r_fill[i_cmd.lvl];
                n_idx = '0;
            end
            CMD_AGE_RD: begin
                re      = 1'b1;
                raddr   = wrap_add(r_head[i_cmd.lvl], r_idx);
                n_waddr = raddr;
            end
            CMD_AGE_WR: begin
                we             = 1'b1;
                wdata.id       = rd.id;
                wdata.wait_cnt = sat_inc(rd.wait_cnt);
                n_idx          = r_idx + CNT_W'(1);
                n_cnt          = r_cnt - CNT_W'(1);
            end
            CMD_ESC_RD: begin
                re = 1'b1;
            end
            CMD_ESC_WR: begin
                // low entries age on this walk
                if (i_cmd.lvl == LVL_L) e.wait_cnt = sat_inc(rd.wait_cnt);
                wdata = e;
                we    = 1'b1;
                move  = (e.wait_cnt > r_thr) &&
                        (r_fill[to_lvl] != CNT_W'(LEVEL_DEPTH));
                n_head[i_cmd.lvl] = wrap_add(r_head[i_cmd.lvl], CNT_W'(1));
                if (move) begin
                    wlvl              = to_lvl;
                    waddr             = wrap_add(r_head[to_lvl], r_fill[to_lvl]);
                    n_fill[to_lvl]    = r_fill[to_lvl] + CNT_W'(1);
                    n_fill[i_cmd.lvl] = r_fill[i_cmd.lvl] - CNT_W'(1);
                end else begin
                    // push back to its own tail
                    waddr = wrap_add(r_head[i_cmd.lvl], r_fill[i_cmd.lvl]);
                end
                n_cnt = r_cnt - CNT_W'(1);
            end
            CMD_POP_RD: begin
                re        = 1'b1;
                rlvl      = pop_q;
                raddr     = r_head[pop_q];
                n_pop_lvl = pop_q;
            end
            CMD_POP_WR: begin
                n_head[r_pop_lvl] = wrap_add(r_head[r_pop_lvl], CNT_W'(1));
                n_fill[r_pop_lvl] = r_fill[r_pop_lvl] - CNT_W'(1);
                if (r_served != {TOTAL_BITS{1'b1}}) n_served = r_served + TOTAL_BITS'(1);
                wsum_ext = (TOTAL_BITS+1)'(r_wsum) + (TOTAL_BITS+1)'(rd.wait_cnt);
                n_wsum   = wsum_ext[TOTAL_BITS] ? {TOTAL_BITS{1'b1}}
                                                : wsum_ext[TOTAL_BITS-1:0];
                n_out               = '0;
                n_out.served_valid  = 1'b1;
                n_out.served_id     = rd.id;
                n_out.served_level  = r_pop_lvl + 2'd1;
                n_out.served_wait   = rd.wait_cnt;
                n_out.total_served  = n_served;
                n_out.total_wait    = n_wsum;
                n_out_valid         = 1'b1;
            end
            CMD_EMPTY: begin
                n_out              = '0;
                n_out.all_empty    = 1'b1;
                n_out.total_served = r_served;
                n_out.total_wait   = r_wsum;
                n_out_valid        = 1'b1;
            end
            CMD_ADMIT: begin
                n_out              = '0;
                n_out.total_served = r_served;
                n_out.total_wait   = r_wsum;
                n_out_valid        = 1'b1;
                if (r_item.level == LEVEL_NONE) begin
                    n_out.admit_dropped = 1'b1;
                end else if (r_fill[adm_idx] == CNT_W'(LEVEL_DEPTH)) begin
                    n_out.admit_dropped = 1'b1;
                end else begin
                    we             = 1'b1;
                    wlvl           = adm_idx;
                    waddr          = wrap_add(r_head[adm_idx], r_fill[adm_idx]);
                    wdata.id       = r_item.entry_id;
                    wdata.wait_cnt = '0;
                    n_fill[adm_idx] = r_fill[adm_idx] + CNT_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '{default: '0};
            r_fill      <= '{default: '0};
            r_served    <= '0;
            r_wsum      <= '0;
            r_thr       <= THR_RESET;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
        end else begin
            r_head      <= n_head;
            r_fill      <= n_fill;
            r_served    <= n_served;
            r_wsum      <= n_wsum;
            r_out_valid <= n_out_valid;
            r_cnt       <= n_cnt;
            if (i_cfg_valid) r_thr <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx     <= n_idx;
        r_waddr   <= n_waddr;
        r_pop_lvl <= n_pop_lvl;
        r_out     <= n_out;
        if (i_cmd.accept) r_item <= i_in;
    end

    assign o_status.cnt_zero  = (r_cnt == '0);
    assign o_status.all_empty = (r_fill[0] == '0) && (r_fill[1] == '0) && (r_fill[2] == '0);
    assign o_status.out_free  = !r_out_valid || i_out_ready;
    assign o_status.item_op   = r_item.op;
    assign o_out_valid        = r_out_valid;
    assign o_out              = r_out;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill[0] <= CNT_W'(LEVEL_DEPTH)) && (r_fill[1] <= CNT_W'(LEVEL_DEPTH)) &&
        (r_fill[2] <= CNT_W'(LEVEL_DEPTH)))
        else $error("level fill count above depth");

    a_walk_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == CMD_AGE_WR || i_cmd.op == CMD_ESC_WR) |-> (r_cnt != '0))
        else $error("walk step with no entries left");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == CMD_POP_WR) |-> (r_fill[r_pop_lvl] != '0))
        else $error("pop from an empty level");

    a_result_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == CMD_POP_WR || i_cmd.op == CMD_EMPTY || i_cmd.op == CMD_ADMIT)
        |-> (!r_out_valid || i_out_ready))
        else $error("result written over a pending one");

endmodule

`default_nettype wire

@@ src/three_level_priority_queue_aging.sv @@
// ---------------------------------------------------------------------------
// three_level_priority_queue_aging
// Three FIFO levels with aging escalation and strict-priority serve.
// ---------------------------------------------------------------------------
// One request at a time. An admit passes through the decode and admit states
// before its result is written. A serve walks the stored entries one at a time
// through each level memory's single read and write port, with a read state and
// a write state per entry: aging the high and middle levels, then escalating low
// and then middle, then popping. The next request is taken once the result is
// written to the output register.
`default_nettype none

module three_level_priority_queue_aging (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_ready,
    input  tlpq_pkg::t_in_item   i_in,
    output logic                 o_out_valid,
    input  wire                  i_out_ready,
    output tlpq_pkg::t_out_item  o_out,
    input  wire                  i_cfg_valid,
    output logic                 o_cfg_ready,
    input  wire [tlpq_pkg::THR_BITS-1:0] i_cfg_data
);
    import tlpq_pkg::*;

    t_cmd    cmd;
    t_status status;

    assign o_cfg_ready = 1'b1;

    tlpq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    tlpq_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_in        (i_in),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire

@@ tb/tb_three_level_priority_queue_aging.sv @@
// ---------------------------------------------------------------------------
// tb_three_level_priority_queue_aging
// Self-checking bench for the three-level aging priority queue. A directed
// table of admits and serves runs first, then random phases of admit bursts
// and serves under several aging thresholds. Every response is compared
// against a local queue model that ages, escalates and serves in step.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_three_level_priority_queue_aging;
    import tlpq_pkg::*;

    localparam int WATCHDOG_LIMIT = 6000;

    logic        i_clk;
    logic        i_rst_n;
    logic        in_valid;
    logic        in_ready;
    t_in_item    in_item;
    logic        out_valid;
    logic        out_ready;
    t_out_item   out_item;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [THR_BITS-1:0] cfg_data;

    three_level_priority_queue_aging u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    // queue model state
    t_entry              level_q [3][$];
    logic [THR_BITS-1:0] age_thr;
    logic [31:0]         served_total;
    logic [31:0]         wait_total;

    t_out_item   resp_q[$];
    int          mismatch_cnt;
    int          resp_cnt;
    int          serve_hits;
    int          drop_cnt;
    int          idle_cycles;
    bit          quiet;
    bit          hold_req;

    typedef struct {
        logic               op;
        logic [ID_BITS-1:0] id;
        logic [1:0]         level;
        bit                 fixed;
        logic               exp_empty;
        logic               exp_drop;
    } t_row;

    t_row rows[$];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void escalate_level(int src, int dst);
        int     n;
        t_entry e;
        n = level_q[src].size();
        for (int i = 0; i < n; i++) begin
            e = level_q[src].pop_front();
            if (e.wait_cnt > age_thr && level_q[dst].size() < LEVEL_DEPTH)
                level_q[dst].push_back(e);
            else
                level_q[src].push_back(e);
        end
    endfunction

    function automatic t_out_item queue_step(t_in_item it);
        t_out_item r;
        t_entry    e;
        int        q;
        logic [32:0] sum;
        r = '0;
        if (it.op == OP_ADMIT) begin
            if (it.level == LEVEL_NONE) begin
                r.admit_dropped = 1'b1;
            end else if (level_q[it.level - 1].size() >= LEVEL_DEPTH) begin
                r.admit_dropped = 1'b1;
            end else begin
                e.id = it.entry_id;
                e.wait_cnt = '0;
                level_q[it.level - 1].push_back(e);
            end
        end else begin
            for (int l = 0; l < 3; l++)
                foreach (level_q[l][k])
                    if (level_q[l][k].wait_cnt != {WAIT_BITS{1'b1}})
                        level_q[l][k].wait_cnt = level_q[l][k].wait_cnt + 1'b1;
            escalate_level(LVL_L, LVL_M);
            escalate_level(LVL_M, LVL_H);
            q = 0;
            while (q < 3 && level_q[q].size() == 0) q++;
            if (q < 3) begin
                e = level_q[q].pop_front();
                r.served_valid = 1'b1;
                r.served_id    = e.id;
                r.served_level = 2'(q + 1);
                r.served_wait  = e.wait_cnt;
                if (served_total != 32'hFFFF_FFFF) served_total = served_total + 1;
                sum = {1'b0, wait_total} + e.wait_cnt;
                wait_total = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
            end else begin
                r.all_empty = 1'b1;
            end
        end
        r.total_served = served_total;
        r.total_wait   = wait_total;
        return r;
    endfunction

    // offer one request, queue its expected response, hold until accepted
    task automatic send_request(t_in_item it, bit fixed = 0, t_out_item fixed_resp = '0);
        t_out_item r;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        r = queue_step(it);
        resp_q.push_back(fixed ? fixed_resp : r);
        do @(posedge i_clk); while (!in_ready);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (resp_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_threshold(logic [THR_BITS-1:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        age_thr = v;
    endtask

    function automatic t_in_item make_admit(logic [1:0] lvl);
        t_in_item it;
        it.op       = OP_ADMIT;
        it.entry_id = ID_BITS'($urandom);
        it.level    = lvl;
        return it;
    endfunction

    function automatic t_in_item make_serve();
        t_in_item it;
        it.op       = OP_SERVE;
        it.entry_id = ID_BITS'($urandom);
        it.level    = 2'($urandom);
        return it;
    endfunction

    // admit bursts and serves with random content, some noise, some floods
    task automatic random_phase(int n_items);
        int sent;
        int k;
        logic [1:0] lvl;
        sent = 0;
        while (sent < n_items) begin
            case ($urandom_range(0, 9))
                0: begin
                    lvl = 2'($urandom_range(1, 3));
                    k = $urandom_range(60, 70);
                    repeat (k) send_request(make_admit(lvl));
                    sent += k;
                end
                1: begin
                    send_request(make_admit(LEVEL_NONE));
                    sent++;
                end
                default: begin
                    k = $urandom_range(1, 8);
                    repeat (k) send_request(make_admit(2'($urandom_range(1, 3))));
                    sent += k;
                    k = $urandom_range(1, 8);
                    repeat (k) send_request(make_serve());
                    sent += k;
                end
            endcase
        end
    endtask

    // response checker
    always @(posedge i_clk) begin
        t_out_item e;
        if (i_rst_n && out_valid && out_ready) begin
            resp_cnt <= resp_cnt + 1;
            if (resp_q.size() == 0) begin
                mismatch_cnt <= mismatch_cnt + 1;
                if (mismatch_cnt < 10) $display("ERROR: response with none pending: %p", out_item);
            end else begin
                e = resp_q.pop_front();
                if (out_item.served_valid) serve_hits <= serve_hits + 1;
                if (out_item.admit_dropped) drop_cnt <= drop_cnt + 1;
                if (out_item.served_valid  !== e.served_valid  ||
                    out_item.served_id     !== e.served_id     ||
                    out_item.served_level  !== e.served_level  ||
                    out_item.served_wait   !== e.served_wait   ||
                    out_item.all_empty     !== e.all_empty     ||
                    out_item.admit_dropped !== e.admit_dropped ||
                    out_item.total_served  !== e.total_served  ||
                    out_item.total_wait    !== e.total_wait) begin
                    mismatch_cnt <= mismatch_cnt + 1;
                    if (mismatch_cnt < 10)
                        $display("ERROR: response %0d expected %p got %p", resp_cnt, e, out_item);
                end
            end
        end
    end

    // receiver stalls, including one long hold so the input backs up
    initial begin
        out_ready <= 1'b0;
        @(posedge i_clk iff i_rst_n);
        out_ready <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 0;
                out_ready <= 1'b0;
                repeat (400) @(posedge i_clk);
                out_ready <= 1'b1;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
                out_ready <= 1'b1;
            end
        end
    end

    // watchdog on cycles with no handshake of any kind
    always @(posedge i_clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("ERROR: watchdog expired with %0d responses pending", resp_q.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        t_in_item  it;
        t_out_item fr;
        i_rst_n      <= 1'b0;
        in_valid     <= 1'b0;
        in_item      <= '0;
        cfg_valid    <= 1'b0;
        cfg_data     <= '0;
        mismatch_cnt = 0;
        resp_cnt     = 0;
        serve_hits   = 0;
        drop_cnt     = 0;
        idle_cycles  = 0;
        quiet        = 0;
        hold_req     = 0;
        age_thr      = THR_RESET;
        served_total = '0;
        wait_total   = '0;

        rows.push_back('{OP_SERVE, 16'hFFFF, LEVEL_LOW,  1, 1'b1, 1'b0});
        rows.push_back('{OP_ADMIT, 16'hFFFF, LEVEL_NONE, 1, 1'b0, 1'b1});
        rows.push_back('{OP_ADMIT, 16'h0000, LEVEL_NONE, 1, 1'b0, 1'b1});
        rows.push_back('{OP_ADMIT, 16'h0000, LEVEL_HIGH, 1, 1'b0, 1'b0});
        rows.push_back('{OP_ADMIT, 16'hFFFF, LEVEL_MID,  1, 1'b0, 1'b0});
        rows.push_back('{OP_ADMIT, 16'h5555, LEVEL_LOW,  1, 1'b0, 1'b0});
        rows.push_back('{OP_ADMIT, 16'hAAAA, LEVEL_LOW,  1, 1'b0, 1'b0});
        rows.push_back('{OP_ADMIT, 16'hFFFF, LEVEL_HIGH, 1, 1'b0, 1'b0});
        rows.push_back('{OP_ADMIT, 16'h0001, LEVEL_MID,  1, 1'b0, 1'b0});
        for (int i = 0; i < 10; i++)
            rows.push_back('{OP_SERVE, 16'(i * 16'h1111), 2'(i), 0, 1'b0, 1'b0});
        rows.push_back('{OP_ADMIT, 16'h8000, LEVEL_LOW,  0, 1'b0, 1'b0});
        rows.push_back('{OP_SERVE, 16'h0000, LEVEL_NONE, 0, 1'b0, 1'b0});
        rows.push_back('{OP_SERVE, 16'h0000, LEVEL_NONE, 0, 1'b0, 1'b0});

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table; the first rows have responses fixed by hand
        foreach (rows[i]) begin
            it.op       = rows[i].op;
            it.entry_id = rows[i].id;
            it.level    = rows[i].level;
            fr = '0;
            fr.all_empty     = rows[i].exp_empty;
            fr.admit_dropped = rows[i].exp_drop;
            send_request(it, rows[i].fixed, fr);
        end

        write_threshold(16'd0);
        random_phase(250);
        write_threshold(16'hFFFF);
        hold_req = 1;
        random_phase(250);
        write_threshold(16'd1);
        random_phase(250);
        write_threshold(16'($urandom_range(2, 40)));
        random_phase(250);
        write_threshold(THR_RESET);
        random_phase(250);
        write_threshold(16'd2);
        quiet = 1;
        random_phase(250);
        drain();

        $display("Covered %0d responses: %0d serves popped an entry, %0d admits dropped,",
                 resp_cnt, serve_hits, drop_cnt);
        $display("thresholds 0, 1, 2, 5, a random one and 65535, full levels and a long stall.");
        if (mismatch_cnt == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("%0d mismatches", mismatch_cnt);
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
